@@ rtl/modular_exponent_block_cipher_assert.svh @@
// Assertion macros shared by the modular exponentiation RTL.
// Relies on the including module having clk_i and rst_ni in scope.
`ifndef MODULAR_EXPONENT_BLOCK_CIPHER_ASSERT_SVH
`define MODULAR_EXPONENT_BLOCK_CIPHER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MEXP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define MEXP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mexp_pkg.sv @@
// Shared types and constants for the modular exponentiation block.
// No dependencies.
package mexp_pkg;

  // Fixed widths of the item fields
  localparam int unsigned BlockBits = 32;
  localparam int unsigned OutBits   = 32;

  // Configuration register indexes
  localparam int unsigned CfgIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] CFG_EXPONENT = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_MODULUS  = 2'd1;

  // Status of the shared modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

@@ rtl/mexp_mulmod.sv @@
// Bit-serial modular multiplier: p = a * b mod m, one bit of b per cycle.
// Depends on mexp_pkg (status struct). Requires a < m and m >= 2.
module mexp_mulmod #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] b_i,
  input  logic [WORD_BITS-1:0] m_i,
  output mexp_pkg::mm_stat_t   stat_o,
  output logic [WORD_BITS-1:0] p_o
);

  localparam int unsigned CntBits = $clog2(WORD_BITS);
  localparam logic [CntBits-1:0] CntTop = CntBits'(WORD_BITS - 1);

  logic                 busy_q, done_q;
  logic [CntBits-1:0]   cnt_q;
  logic [WORD_BITS-1:0] acc_q, a_q, b_q;
  logic [WORD_BITS-1:0] acc_d;

  logic [WORD_BITS+1:0] sum;
  logic [WORD_BITS+2:0] sub1, sub2;

  // 2*acc + bit*a lies below 3m: subtract m or 2m, chosen by borrow
  always_comb begin
    sum  = {1'b0, acc_q, 1'b0} + {2'b00, (b_q[WORD_BITS-1] ? a_q : '0)};
    sub1 = {1'b0, sum} - {3'b000, m_i};
    sub2 = {1'b0, sum} - {2'b00, m_i, 1'b0};
    if (!sub2[WORD_BITS+2]) begin
      acc_d = sub2[WORD_BITS-1:0];
    end else if (!sub1[WORD_BITS+2]) begin
      acc_d = sub1[WORD_BITS-1:0];
    end else begin
      acc_d = sum[WORD_BITS-1:0];
    end
  end

  // Sequencing: bit counter, busy and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntTop;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Datapath: operands latched at start, accumulator stepped while busy
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[WORD_BITS-2:0], 1'b0};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign p_o         = acc_q;

endmodule

@@ rtl/modular_exponent_block_cipher.sv @@
// Modular exponentiation block cipher (RSA style): result = block ^ exponent mod modulus.
// Top level: sequencer around mexp_mulmod; uses mexp_pkg and the assertion header.
//
// One block at a time. An accepted block is first reduced modulo the modulus,
// then square-and-multiply walks the exponent from its top bit. Every modular
// product goes through the single shared bit-serial multiplier. A modulus
// below two gives result 0. A finished result sits in an output register, so
// the next block can be taken while it waits. Configuration (index 0 exponent,
// index 1 modulus) is always ready and must be written only while idle.
`include "modular_exponent_block_cipher_assert.svh"

module modular_exponent_block_cipher #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input block channel
  input  logic [mexp_pkg::BlockBits-1:0]      block_i,
  input  logic                                block_valid_i,
  output logic                                block_stall_o,
  // result channel
  output logic [mexp_pkg::OutBits-1:0]        result_o,
  output logic                                result_valid_o,
  input  logic                                result_stall_i,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mexp_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [WORD_BITS-1:0]                cfg_data_i
);

  localparam int unsigned IdxBits = $clog2(WORD_BITS);
  localparam logic [IdxBits-1:0] IdxTop = IdxBits'(WORD_BITS - 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_SQUARE = 3'd2;
  localparam logic [2:0] ST_MULT   = 3'd3;
  localparam logic [2:0] ST_HOLD   = 3'd4;

  logic [2:0]                    state_q, state_d;
  logic [IdxBits-1:0]            idx_q, idx_d;
  logic                          mm_start_q, mm_start_d;
  logic                          out_valid_q, out_valid_d;
  logic [WORD_BITS-1:0]          exp_q, mod_q;
  logic [WORD_BITS-1:0]          op_a_q, op_a_d, op_b_q, op_b_d;
  logic [WORD_BITS-1:0]          base_q, base_d, acc_q, acc_d;
  logic [mexp_pkg::OutBits-1:0]  res_q, res_d;

  logic [WORD_BITS-1:0]          blk_w;
  logic [mexp_pkg::OutBits-1:0]  acc_lo;
  logic [WORD_BITS-1:0]          mm_p;
  mexp_pkg::mm_stat_t            mm_stat;
  logic                          blk_xfer, res_xfer, slot_free;

  // Width adaptation between item fields and the working word
  if (WORD_BITS >= mexp_pkg::BlockBits) begin : g_wide
    assign blk_w  = WORD_BITS'(block_i);
    assign acc_lo = acc_q[mexp_pkg::OutBits-1:0];
  end else begin : g_narrow
    assign blk_w  = block_i[WORD_BITS-1:0];
    assign acc_lo = mexp_pkg::OutBits'(acc_q);
  end

  // Handshakes
  assign block_stall_o  = (state_q != ST_IDLE);
  assign blk_xfer       = block_valid_i && !block_stall_o;
  assign result_valid_o = out_valid_q;
  assign result_o       = res_q;
  assign res_xfer       = out_valid_q && !result_stall_i;
  assign slot_free      = !out_valid_q || !result_stall_i;
  assign cfg_ready_o    = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= WORD_BITS'(3);
      mod_q <= WORD_BITS'(2);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mexp_pkg::CFG_EXPONENT: exp_q <= cfg_data_i;
        mexp_pkg::CFG_MODULUS:  mod_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Shared modular multiplier
  mexp_mulmod #(
    .WORD_BITS (WORD_BITS)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start_q),
    .a_i     (op_a_q),
    .b_i     (op_b_q),
    .m_i     (mod_q),
    .stat_o  (mm_stat),
    .p_o     (mm_p)
  );

  // Square-and-multiply sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    mm_start_d  = 1'b0;
    out_valid_d = out_valid_q;
    op_a_d      = op_a_q;
    op_b_d      = op_b_q;
    base_d      = base_q;
    acc_d       = acc_q;
    res_d       = res_q;

    if (res_xfer) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (blk_xfer) begin
          if (mod_q < WORD_BITS'(2)) begin
            acc_d   = '0;
            state_d = ST_HOLD;
          end else begin
            // reduce block: shift its bits into 1 * block mod m
            op_a_d     = WORD_BITS'(1);
            op_b_d     = blk_w;
            mm_start_d = 1'b1;
            state_d    = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_stat.done) begin
          base_d     = mm_p;
          op_a_d     = WORD_BITS'(1);
          op_b_d     = WORD_BITS'(1);
          idx_d      = IdxTop;
          mm_start_d = 1'b1;
          state_d    = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (mm_stat.done) begin
          acc_d = mm_p;
          if (exp_q[idx_q]) begin
            op_a_d     = mm_p;
            op_b_d     = base_q;
            mm_start_d = 1'b1;
            state_d    = ST_MULT;
          end else if (idx_q == '0) begin
            state_d = ST_HOLD;
          end else begin
            idx_d      = idx_q - 1'b1;
            op_a_d     = mm_p;
            op_b_d     = mm_p;
            mm_start_d = 1'b1;
          end
        end
      end
      ST_MULT: begin
        if (mm_stat.done) begin
          acc_d = mm_p;
          if (idx_q == '0) begin
            state_d = ST_HOLD;
          end else begin
            idx_d      = idx_q - 1'b1;
            op_a_d     = mm_p;
            op_b_d     = mm_p;
            mm_start_d = 1'b1;
            state_d    = ST_SQUARE;
          end
        end
      end
      ST_HOLD: begin
        // wait for the output register to free up
        if (slot_free) begin
          res_d       = acc_lo;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      mm_start_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      mm_start_q  <= mm_start_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_a_q <= op_a_d;
    op_b_q <= op_b_d;
    base_q <= base_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

  // Assertions
  `MEXP_ASSERT_NXT(a_accept_busy, blk_xfer, state_q != ST_IDLE,
                   "block transfer did not leave idle")
  `MEXP_ASSERT_IMP(a_start_free, mm_start_q, !mm_stat.busy,
                   "multiplier started while busy")
  `MEXP_ASSERT_IMP(a_done_state, mm_stat.done,
                   state_q == ST_REDUCE || state_q == ST_SQUARE || state_q == ST_MULT,
                   "multiplier done outside a product state")
  `MEXP_ASSERT_NXT(a_small_mod, blk_xfer && (mod_q < WORD_BITS'(2)),
                   state_q == ST_HOLD && acc_q == '0,
                   "modulus below two did not give zero")

endmodule
